[design/brbo_pkg.sv]
// Shared constants, action codes and payload types of the byte ring buffer.
package brbo_pkg;

  localparam int unsigned DEPTH    = 256;
  localparam int unsigned IDX_W    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CNT_W    = $clog2(DEPTH + 1);
  localparam int unsigned FILL_W   = 9;
  localparam int unsigned DROP_W   = 16;

  typedef enum logic [1:0] {
    ACT_PUSH_TAIL = 2'd0,
    ACT_POP       = 2'd1,
    ACT_PUSH_HEAD = 2'd2,
    ACT_IDLE      = 2'd3
  } action_e;

  typedef struct packed {
    logic [1:0] action;
    logic [7:0] data_in;
    logic       chunk_end;
  } in_item_t;

  typedef struct packed {
    logic [7:0]        data_out;
    logic              data_valid;
    logic              dropped;
    logic [DROP_W-1:0] dropped_in_chunk;
    logic [FILL_W-1:0] fill_count;
  } out_item_t;

  // Result flags computed by the pointer logic; the byte comes from the store.
  typedef struct packed {
    logic              data_valid;
    logic              dropped;
    logic [DROP_W-1:0] dropped_in_chunk;
    logic [FILL_W-1:0] fill_count;
  } status_t;

  // Access to the byte store for one transfer.
  typedef struct packed {
    logic             we;
    logic [IDX_W-1:0] waddr;
    logic [7:0]       wdata;
    logic [IDX_W-1:0] raddr;
  } mem_req_t;

endpackage

[design/brbo_if.sv]
// Valid/ready channel interfaces for the input and result streams.
interface brbo_in_if import brbo_pkg::*; ();
  logic     valid;
  logic     ready;
  in_item_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

interface brbo_out_if import brbo_pkg::*; ();
  logic      valid;
  logic      ready;
  out_item_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

[design/brbo_ram.sv]
// Generic single-write, single-read RAM with registered read data.
module brbo_ram #(
  parameter int unsigned Depth = 256,
  parameter int unsigned Width = 8
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

[design/brbo_ctrl.sv]
// Head pointer, fill count and per-chunk drop counter of the ring buffer.
module brbo_ctrl import brbo_pkg::*; (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     accept_i,
  input  in_item_t item_i,
  output mem_req_t mem_req_o,
  output status_t  status_o
);

  localparam logic [IDX_W-1:0]  LastIdx  = IDX_W'(DEPTH - 1);
  localparam logic [CNT_W-1:0]  FullCnt  = CNT_W'(DEPTH);
  localparam logic [CNT_W:0]    DepthW   = (CNT_W + 1)'(DEPTH);
  localparam logic [DROP_W-1:0] DropMax  = '1;

  logic [IDX_W-1:0]  head_q, head_d;
  logic [CNT_W-1:0]  count_q, count_d;
  logic [DROP_W-1:0] drops_q, drops_d;
  status_t           status_q, status_d;

  logic              full, empty, drop;
  logic [CNT_W:0]    tail_sum, tail_wrap;
  logic [IDX_W-1:0]  tail_idx, head_inc, head_dec;
  logic [DROP_W-1:0] drops_item;
  logic [31:0]       count_wide;

  assign full  = (count_q == FullCnt);
  assign empty = (count_q == '0);

  // head + count stays below twice the depth, so one subtract wraps it.
  assign tail_sum  = (CNT_W + 1)'(head_q) + (CNT_W + 1)'(count_q);
  assign tail_wrap = (tail_sum >= DepthW) ? tail_sum - DepthW : tail_sum;
  assign tail_idx  = tail_wrap[IDX_W-1:0];
  assign head_inc  = (head_q == LastIdx) ? '0 : head_q + IDX_W'(1);
  assign head_dec  = (head_q == '0) ? LastIdx : head_q - IDX_W'(1);

  always_comb begin
    head_d          = head_q;
    count_d         = count_q;
    drop            = 1'b0;
    mem_req_o.we    = 1'b0;
    mem_req_o.waddr = tail_idx;
    mem_req_o.wdata = item_i.data_in;
    mem_req_o.raddr = head_q;
    status_d        = status_q;
    status_d.data_valid = 1'b0;
    case (action_e'(item_i.action))
      ACT_PUSH_TAIL: begin
        mem_req_o.we = 1'b1;
        if (full) begin
          // The tail slot is the oldest byte, which is overwritten.
          head_d = head_inc;
          drop   = 1'b1;
        end else begin
          count_d = count_q + CNT_W'(1);
        end
      end
      ACT_POP: begin
        if (!empty) begin
          status_d.data_valid = 1'b1;
          head_d  = head_inc;
          count_d = count_q - CNT_W'(1);
        end
      end
      ACT_PUSH_HEAD: begin
        // When full, the slot before the head holds the newest byte.
        mem_req_o.we    = 1'b1;
        mem_req_o.waddr = head_dec;
        head_d          = head_dec;
        if (full) begin
          drop = 1'b1;
        end else begin
          count_d = count_q + CNT_W'(1);
        end
      end
      default: begin
      end
    endcase

    drops_item = (drop && drops_q != DropMax) ? drops_q + DROP_W'(1) : drops_q;
    drops_d    = item_i.chunk_end ? '0 : drops_item;
    count_wide = 32'(count_d);
    status_d.dropped          = drop;
    status_d.dropped_in_chunk = drops_item;
    status_d.fill_count       = count_wide[FILL_W-1:0];
    mem_req_o.we              = mem_req_o.we & accept_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      head_q  <= '0;
      count_q <= '0;
      drops_q <= '0;
    end else if (accept_i) begin
      head_q  <= head_d;
      count_q <= count_d;
      drops_q <= drops_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept_i) begin
      status_q <= status_d;
    end
  end

  assign status_o = status_q;

endmodule

[design/byte_ring_buffer_overwrite_unget_unit.sv]
// Top level of the byte ring buffer with overwrite of the oldest byte and unget.
//
//   port    role    payload                                             transfer
//   in_i    sink    action, data_in, chunk_end                          valid & ready
//   out_o   source  data_out, data_valid, dropped, dropped_in_chunk,    valid & ready
//                   fill_count
//
// One result per item, in the next cycle; one item per cycle while results go out.
// Pointer update, byte-store write and byte-store read finish in the transfer cycle.
// The input is ready whenever the result register is empty or is being taken.
// Reset clears head, fill count and drop count; the byte store needs no clearing.
module byte_ring_buffer_overwrite_unget_unit import brbo_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  brbo_in_if.sink     in_i,
  brbo_out_if.source  out_o
);

  logic     accept;
  logic     out_valid_q;
  mem_req_t mem_req;
  status_t  status;
  logic [7:0] rdata;

  assign in_i.ready = !out_valid_q || out_o.ready;
  assign accept     = in_i.valid && in_i.ready;

  brbo_ctrl u_ctrl (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .accept_i  (accept),
    .item_i    (in_i.data),
    .mem_req_o (mem_req),
    .status_o  (status)
  );

  brbo_ram #(
    .Depth (DEPTH),
    .Width (8)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (mem_req.we),
    .waddr_i (mem_req.waddr),
    .wdata_i (mem_req.wdata),
    .re_i    (accept),
    .raddr_i (mem_req.raddr),
    .rdata_o (rdata)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (accept) begin
      out_valid_q <= 1'b1;
    end else if (out_o.ready) begin
      out_valid_q <= 1'b0;
    end
  end

  assign out_o.valid                 = out_valid_q;
  assign out_o.data.data_out         = status.data_valid ? rdata : 8'h00;
  assign out_o.data.data_valid       = status.data_valid;
  assign out_o.data.dropped          = status.dropped;
  assign out_o.data.dropped_in_chunk = status.dropped_in_chunk;
  assign out_o.data.fill_count       = status.fill_count;

endmodule

[test/brbo_checker.sv]
// Checker that predicts each result of the byte ring buffer and compares it with the block.
`timescale 1ns / 100ps

module brbo_checker import brbo_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  brbo_in_if          in_mon,
  brbo_out_if         out_mon,
  output int unsigned fail_count_o,
  output int unsigned pending_o
);

  localparam int unsigned REPORT_LIMIT = 10;
  localparam int unsigned DROP_MAX     = (1 << DROP_W) - 1;

  // Shadow copy of the ring and its pointers.
  logic [7:0]  ring_mem [DEPTH];
  int unsigned head_ptr;
  int unsigned held_bytes;
  int unsigned chunk_drops;

  out_item_t   pending_results [$];
  int unsigned fail_total;
  int unsigned report_count;

  // Applies one action to the shadow ring and returns the result it should produce.
  function automatic out_item_t apply_action(in_item_t item);
    out_item_t res;
    res = '0;
    case (action_e'(item.action))
      ACT_PUSH_TAIL: begin
        if (held_bytes < DEPTH) begin
          ring_mem[(head_ptr + held_bytes) % DEPTH] = item.data_in;
          held_bytes++;
        end else begin
          // Full: the tail slot is the oldest entry, so the head moves on.
          ring_mem[head_ptr] = item.data_in;
          head_ptr = (head_ptr + 1) % DEPTH;
          res.dropped = 1'b1;
        end
      end
      ACT_POP: begin
        if (held_bytes != 0) begin
          res.data_out   = ring_mem[head_ptr];
          res.data_valid = 1'b1;
          head_ptr = (head_ptr + 1) % DEPTH;
          held_bytes--;
        end
      end
      ACT_PUSH_HEAD: begin
        // When full, the slot in front of the head holds the newest byte.
        head_ptr = (head_ptr + DEPTH - 1) % DEPTH;
        ring_mem[head_ptr] = item.data_in;
        if (held_bytes < DEPTH) begin
          held_bytes++;
        end else begin
          res.dropped = 1'b1;
        end
      end
      default: begin
      end
    endcase
    if (res.dropped && chunk_drops < DROP_MAX) begin
      chunk_drops++;
    end
    res.dropped_in_chunk = DROP_W'(chunk_drops);
    res.fill_count       = FILL_W'(held_bytes);
    if (item.chunk_end) begin
      chunk_drops = 0;
    end
    return res;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    out_item_t want;
    out_item_t got;
    if (!rst_ni) begin
      head_ptr     = 0;
      held_bytes   = 0;
      chunk_drops  = 0;
      fail_total   = 0;
      report_count = 0;
      pending_results.delete();
      fail_count_o <= 0;
      pending_o    <= 0;
    end else begin
      // The result leaving now belongs to an earlier transfer, so check it first.
      if (out_mon.valid && out_mon.ready) begin
        got = out_mon.data;
        if (pending_results.size() == 0) begin
          fail_total++;
          if (report_count < REPORT_LIMIT) begin
            report_count++;
            $display("%0t: result with nothing awaited: data_out=%0h valid=%0b dropped=%0b",
                     $realtime, got.data_out, got.data_valid, got.dropped);
          end
        end else begin
          want = pending_results.pop_front();
          if (got.data_out !== want.data_out || got.data_valid !== want.data_valid ||
              got.dropped !== want.dropped ||
              got.dropped_in_chunk !== want.dropped_in_chunk ||
              got.fill_count !== want.fill_count) begin
            fail_total++;
            if (report_count < REPORT_LIMIT) begin
              report_count++;
              $display("%0t: mismatch expected data_out=%0h valid=%0b dropped=%0b chunk=%0d fill=%0d",
                       $realtime, want.data_out, want.data_valid, want.dropped,
                       want.dropped_in_chunk, want.fill_count);
              $display("%0t:          actual   data_out=%0h valid=%0b dropped=%0b chunk=%0d fill=%0d",
                       $realtime, got.data_out, got.data_valid, got.dropped,
                       got.dropped_in_chunk, got.fill_count);
            end
          end
        end
      end
      if (in_mon.valid && in_mon.ready) begin
        pending_results.push_back(apply_action(in_mon.data));
      end
      fail_count_o <= fail_total;
      pending_o    <= pending_results.size();
    end
  end

endmodule

[test/testbench.sv]
// Top of the byte ring buffer testbench: clock, reset, stimulus, receiver stalls and verdict.
`timescale 1ns / 100ps

module testbench;
  import brbo_pkg::*;

  localparam int unsigned RANDOM_ITEMS = 1300;
  localparam int unsigned LONG_HOLD    = 400;
  localparam int unsigned QUIET_LIMIT  = 5000;

  logic        clk_i  = 1'b0;
  logic        rst_ni = 1'b0;
  int unsigned fail_count;
  int unsigned pending_count;

  // Both sides run without gaps while this is set; a request for a long receiver stall.
  bit          steady;
  bit          hold_out;
  int unsigned random_sent;

  brbo_in_if  in_ch ();
  brbo_out_if out_ch ();

  byte_ring_buffer_overwrite_unget_unit i_dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (in_ch),
    .out_o  (out_ch)
  );

  brbo_checker i_checker (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_mon       (in_ch),
    .out_mon      (out_ch),
    .fail_count_o (fail_count),
    .pending_o    (pending_count)
  );

  always begin
    #6 clk_i = 1'b1;
    #6 clk_i = 1'b0;
  end

  // Mostly no gap, often a short one, now and then a long one.
  function automatic int unsigned idle_len();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 55) begin
      return 0;
    end else if (r < 90) begin
      return $urandom_range(1, 3);
    end
    return $urandom_range(8, 40);
  endfunction

  task automatic send_byte(input action_e act, input logic [7:0] value, input logic last);
    in_item_t    item;
    int unsigned gap;
    item.action    = act;
    item.data_in   = value;
    item.chunk_end = last;
    in_ch.valid <= 1'b1;
    in_ch.data  <= item;
    @(posedge clk_i);
    while (!in_ch.ready) begin
      @(posedge clk_i);
    end
    gap = steady ? 0 : idle_len();
    if (gap != 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
  endtask

  // Sender stops offering until every awaited result has come out.
  task automatic drain_results();
    in_ch.valid <= 1'b0;
    @(posedge clk_i);
    while (pending_count != 0) begin
      @(posedge clk_i);
    end
  endtask

  task automatic run_burst(input action_e act, input int unsigned len);
    for (int unsigned i = 0; i < len; i++) begin
      send_byte(act, 8'($urandom), (i == len - 1) ? 1'b1 : 1'($urandom_range(0, 9) == 0));
    end
    random_sent += len;
  endtask

  function automatic int unsigned burst_len();
    if ($urandom_range(0, 99) < 15) begin
      return $urandom_range(200, 300);
    end
    return $urandom_range(1, 24);
  endfunction

  initial begin : ready_gen
    int unsigned gap;
    out_ch.ready = 1'b0;
    wait (rst_ni);
    @(posedge clk_i);
    forever begin
      if (hold_out) begin
        out_ch.ready <= 1'b0;
        repeat (LONG_HOLD) @(posedge clk_i);
        hold_out = 1'b0;
      end else if (steady) begin
        out_ch.ready <= 1'b1;
        @(posedge clk_i);
      end else begin
        out_ch.ready <= 1'b1;
        repeat ($urandom_range(1, 8)) @(posedge clk_i);
        gap = idle_len();
        if (gap != 0 && !steady) begin
          out_ch.ready <= 1'b0;
          repeat (gap) @(posedge clk_i);
        end
      end
    end
  end

  initial begin : watchdog
    int unsigned quiet;
    quiet = 0;
    forever begin
      @(posedge clk_i);
      if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) begin
        quiet = 0;
      end else begin
        quiet++;
      end
      if (quiet >= QUIET_LIMIT) begin
        $display("FAIL byte_ring_buffer_overwrite_unget_unit");
        $finish;
      end
    end
  end

  initial begin : stimulus
    int unsigned kind;
    int unsigned len;
    in_ch.valid = 1'b0;
    in_ch.data  = '0;
    steady      = 1'b0;
    hold_out    = 1'b0;
    random_sent = 0;
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Empty buffer, idle items, extreme bytes and an unget chunk read back.
    send_byte(ACT_POP,       8'hFF, 1'b0);
    send_byte(ACT_POP,       8'h00, 1'b1);
    send_byte(ACT_IDLE,      8'hFF, 1'b1);
    send_byte(ACT_IDLE,      8'h00, 1'b0);
    send_byte(ACT_PUSH_TAIL, 8'h00, 1'b0);
    send_byte(ACT_PUSH_TAIL, 8'hFF, 1'b0);
    send_byte(ACT_PUSH_TAIL, 8'h55, 1'b1);
    send_byte(ACT_PUSH_HEAD, 8'hAA, 1'b0);
    send_byte(ACT_PUSH_HEAD, 8'h01, 1'b1);
    for (int unsigned i = 0; i < 6; i++) begin
      send_byte(ACT_POP, 8'h00, (i == 5) ? 1'b1 : 1'b0);
    end
    send_byte(ACT_PUSH_HEAD, 8'h80, 1'b0);
    send_byte(ACT_PUSH_TAIL, 8'h7F, 1'b1);
    send_byte(ACT_IDLE,      8'h5A, 1'b0);
    send_byte(ACT_POP,       8'h00, 1'b0);
    send_byte(ACT_POP,       8'h00, 1'b1);
    drain_results();

    // Hold off the receiver, then fill past full and unget into the full buffer.
    hold_out = 1'b1;
    run_burst(ACT_PUSH_TAIL, 300);
    run_burst(ACT_PUSH_HEAD, 8);
    drain_results();

    // Back-to-back overwrites and an unget while the buffer stays full.
    steady = 1'b1;
    send_byte(ACT_PUSH_HEAD, 8'($urandom), 1'b0);
    send_byte(ACT_PUSH_TAIL, 8'($urandom), 1'b1);
    send_byte(ACT_PUSH_TAIL, 8'($urandom), 1'b1);
    steady = 1'b0;
    run_burst(ACT_POP, 270);

    while (random_sent < RANDOM_ITEMS) begin
      steady = ($urandom_range(0, 4) == 0);
      kind = $urandom_range(0, 9);
      len  = burst_len();
      case (kind)
        0, 1, 2: run_burst(ACT_PUSH_TAIL, len);
        3, 4:    run_burst(ACT_POP, len);
        5, 6:    run_burst(ACT_PUSH_HEAD, $urandom_range(1, 16));
        7:       run_burst(ACT_PUSH_HEAD, len);
        default: begin
          len = $urandom_range(1, 20);
          for (int unsigned i = 0; i < len; i++) begin
            send_byte(action_e'($urandom_range(0, 3)), 8'($urandom), 1'($urandom));
          end
          random_sent += len;
        end
      endcase
      if ($urandom_range(0, 11) == 0) begin
        drain_results();
      end else if ($urandom_range(0, 29) == 0) begin
        hold_out = 1'b1;
      end
    end
    steady = 1'b0;

    drain_results();
    repeat (4) @(posedge clk_i);
    if (fail_count == 0) begin
      $display("PASS byte_ring_buffer_overwrite_unget_unit");
    end else begin
      $display("FAIL byte_ring_buffer_overwrite_unget_unit");
    end
    $finish;
  end

endmodule
